// ===== hdl/vbs_pkg.sv =====
// Package for the voxel box statistics block.
// Holds the request and result types, opcode and status codes and the
// control structs shared by the core and its arithmetic unit. No dependencies.
package vbs_pkg;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_RANGE  = 2'd1;
	localparam logic [1:0] OP_STDDEV = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE = 2'd2;

	localparam logic [1:0] CFG_SIZE_X = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z = 2'd2;

	localparam logic [6:0] SIZE_RESET = 7'd64;

	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] lo_x;
		logic [6:0] lo_y;
		logic [6:0] lo_z;
		logic [6:0] hi_x;
		logic [6:0] hi_y;
		logic [6:0] hi_z;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} vbs_in_t;

	typedef struct packed {
		logic [7:0]  mean_red;
		logic [7:0]  mean_green;
		logic [7:0]  mean_blue;
		logic [7:0]  mean_alpha;
		logic [7:0]  widest_range;
		logic [15:0] deviation_q8_8;
		logic [1:0]  status;
	} vbs_out_t;

	typedef struct packed {
		logic start;
		logic stddev;
	} vbs_arith_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] dev;
	} vbs_arith_rsp_t;

endpackage

// ===== hdl/vbs_voxel_ram.sv =====
// Single-port synchronous voxel memory, one 32-bit RGBA word per entry.
// Read data is registered. No dependencies.
module vbs_voxel_ram #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/vbs_arith.sv =====
// Sequential arithmetic unit: four means by restoring division, the variance
// numerator by shift-add multiplication, its scaled quotient and a digit square root.
// Depends on vbs_pkg.
module vbs_arith import vbs_pkg::*; #(
	parameter int NW  = 21,
	parameter int S1W = 29,
	parameter int S2W = 37
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vbs_arith_req_t        req,
	input  logic [NW-1:0]         n,
	input  logic [3:0][S1W-1:0]   sum1,
	input  logic [3:0][S2W-1:0]   sum2,
	output vbs_arith_rsp_t        rsp,
	output logic [3:0][7:0]       means
);

	localparam int N2W   = 2 * NW;
	localparam int NUMW  = NW + S2W;
	localparam int RW    = N2W + 1;
	localparam int MAXST = (S1W > 32) ? S1W : 32;
	localparam int STW   = $clog2(MAXST + 1);

	localparam logic [2:0] A_IDLE  = 3'd0;
	localparam logic [2:0] A_MEAN  = 3'd1;
	localparam logic [2:0] A_N2    = 3'd2;
	localparam logic [2:0] A_MS2   = 3'd3;
	localparam logic [2:0] A_MS1   = 3'd4;
	localparam logic [2:0] A_VLOAD = 3'd5;
	localparam logic [2:0] A_VDIV  = 3'd6;
	localparam logic [2:0] A_SQRT  = 3'd7;

	logic [2:0]      st_q;
	logic            stddev_q;
	logic [1:0]      ch_q;
	logic [STW-1:0]  cnt_q;
	logic [NUMW-1:0] mcand_q;
	logic [S1W-1:0]  mplier_q;
	logic [N2W-1:0]  n2_q;
	logic [NUMW-1:0] num_q;
	logic [RW-1:0]   rem_q;
	logic [N2W-1:0]  dv_q;
	logic [31:0]     low_q;
	logic [31:0]     quo_q;
	logic [17:0]     srem_q;
	logic [15:0]     root_q;
	logic [3:0][7:0] means_q;
	logic            done_q;

	logic [RW-1:0]   trial;
	logic            ge;
	logic [RW-1:0]   rem_next;
	logic [NUMW-1:0] addend;
	logic [19:0]     s_sh;
	logic [19:0]     s_trial;
	logic            s_ge;
	logic            last;

	always_comb begin
		trial    = {rem_q[RW-2:0], low_q[31]};
		ge       = trial >= {1'b0, dv_q};
		rem_next = ge ? (trial - {1'b0, dv_q}) : trial;
		addend   = mplier_q[0] ? mcand_q : '0;
		s_sh     = {srem_q, low_q[31:30]};
		s_trial  = {2'b00, root_q, 2'b01};
		s_ge     = s_sh >= s_trial;
		last     = (cnt_q == STW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= A_IDLE;
			done_q   <= 1'b0;
			stddev_q <= 1'b0;
			ch_q     <= 2'd0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						stddev_q <= req.stddev;
						ch_q     <= 2'd0;
						rem_q    <= RW'(sum1[0] >> 8);
						low_q    <= {sum1[0][7:0], 24'd0};
						dv_q     <= N2W'(n);
						quo_q    <= '0;
						cnt_q    <= STW'(8);
						st_q     <= A_MEAN;
					end
				end
				A_MEAN: begin
					if (last) begin
						means_q[ch_q] <= {quo_q[6:0], ge};
						if (ch_q == 2'd3) begin
							if (stddev_q) begin
								mcand_q  <= NUMW'(n);
								mplier_q <= S1W'(n);
								n2_q     <= '0;
								cnt_q    <= STW'(NW);
								st_q     <= A_N2;
							end else begin
								done_q <= 1'b1;
								st_q   <= A_IDLE;
							end
						end else begin
							ch_q  <= ch_q + 1'b1;
							rem_q <= RW'(sum1[ch_q + 1'b1] >> 8);
							low_q <= {sum1[ch_q + 1'b1][7:0], 24'd0};
							quo_q <= '0;
							cnt_q <= STW'(8);
						end
					end else begin
						rem_q <= rem_next;
						low_q <= {low_q[30:0], 1'b0};
						quo_q <= {quo_q[30:0], ge};
						cnt_q <= cnt_q - 1'b1;
					end
				end
				A_N2: begin
					n2_q <= n2_q + addend[N2W-1:0];
					if (last) begin
						ch_q     <= 2'd0;
						num_q    <= '0;
						mcand_q  <= NUMW'(sum2[0]);
						mplier_q <= S1W'(n);
						cnt_q    <= STW'(NW);
						st_q     <= A_MS2;
					end else begin
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
				A_MS2: begin
					num_q <= num_q + addend;
					if (last) begin
						mcand_q  <= NUMW'(sum1[ch_q]);
						mplier_q <= sum1[ch_q];
						cnt_q    <= STW'(S1W);
						st_q     <= A_MS1;
					end else begin
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
				A_MS1: begin
					// Per channel n*S2 never falls below S1 squared, so this never goes negative.
					num_q <= num_q - addend;
					if (last) begin
						if (ch_q == 2'd3) begin
							st_q <= A_VLOAD;
						end else begin
							ch_q     <= ch_q + 1'b1;
							mcand_q  <= NUMW'(sum2[ch_q + 1'b1]);
							mplier_q <= S1W'(n);
							cnt_q    <= STW'(NW);
							st_q     <= A_MS2;
						end
					end else begin
						mcand_q  <= mcand_q << 1;
						mplier_q <= mplier_q >> 1;
						cnt_q    <= cnt_q - 1'b1;
					end
				end
				A_VLOAD: begin
					// The quotient of num * 2^16 by n^2 fits 32 bits, so the top part
					// of the dividend is already below the divisor.
					rem_q <= RW'(num_q >> 16);
					low_q <= {num_q[15:0], 16'd0};
					dv_q  <= n2_q;
					quo_q <= '0;
					cnt_q <= STW'(32);
					st_q  <= A_VDIV;
				end
				A_VDIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[30:0], ge};
					if (last) begin
						low_q  <= {quo_q[30:0], ge};
						srem_q <= '0;
						root_q <= '0;
						cnt_q  <= STW'(16);
						st_q   <= A_SQRT;
					end else begin
						low_q <= {low_q[30:0], 1'b0};
						cnt_q <= cnt_q - 1'b1;
					end
				end
				A_SQRT: begin
					srem_q <= s_ge ? 18'(s_sh - s_trial) : 18'(s_sh);
					root_q <= {root_q[14:0], s_ge};
					low_q  <= {low_q[29:0], 2'b00};
					cnt_q  <= cnt_q - 1'b1;
					if (last) begin
						done_q <= 1'b1;
						st_q   <= A_IDLE;
					end
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.dev  = root_q;
	assign means    = means_q;

endmodule

// ===== hdl/voxel_box_statistics_core.sv =====
// Voxel box statistics core: a write passes from idle straight to the finish state; a query
// scans the box in memory, then divides out the mean of each channel and, for a stddev
// query, runs the serial multiply, divide and root.
// One item is in work at a time; the next is taken once the result is handed on.
// After reset a clearing pass writes zero to all MAX_SIDE^3 voxels, one per cycle,
// before the first request is taken; size registers reset to 64.
module voxel_box_statistics_core import vbs_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  vbs_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output vbs_out_t   out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int EXT   = (MAX_SIDE < 127) ? MAX_SIDE : 127;
	localparam int CW    = $clog2(EXT + 1);
	localparam int NW    = 3 * CW;
	localparam int S1W   = NW + 8;
	localparam int S2W   = NW + 16;
	localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] SIDE = AW'(MAX_SIDE);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_PREP1  = 3'd2;
	localparam logic [2:0] S_PREP2  = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_DRAIN  = 3'd5;
	localparam logic [2:0] S_ARITH  = 3'd6;
	localparam logic [2:0] S_FINISH = 3'd7;

	function automatic logic [CW-1:0] eff_of(input logic [6:0] s);
		if ({1'b0, s} > 8'(EXT)) return CW'(EXT);
		return CW'(s);
	endfunction

	function automatic logic [CW-1:0] clamp_of(input logic [6:0] v, input logic [CW-1:0] lim);
		if ({1'b0, v} > 8'(lim)) return lim;
		return CW'(v);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z);
		return (AW'(z) * SIDE + AW'(y)) * SIDE + AW'(x);
	endfunction

	logic [2:0]     state_q;
	logic [6:0]     size_x_q, size_y_q, size_z_q;
	logic [AW-1:0]  clr_q;
	logic           stddev_q;
	logic [CW-1:0]  x0_q, y0_q, x1_q, y1_q, z1_q;
	logic [CW-1:0]  cx_q, cy_q, cz_q;
	logic [CW-1:0]  dx_q, dy_q, dz_q;
	logic [2*CW-1:0] nxy_q;
	logic [NW-1:0]  n_q;
	logic           rd_valid_s1;
	logic           arith_go_q;
	logic [3:0][S1W-1:0] sum1_q;
	logic [3:0][S2W-1:0] sum2_q;
	logic [3:0][7:0] mn_q, mx_q;
	vbs_out_t       res_q, out_q;
	logic           out_valid_q;

	logic [CW-1:0]  ex, ey, ez;
	logic [CW-1:0]  qx0, qy0, qz0, qx1, qy1, qz1;
	logic           in_acc;
	logic           wr_inside;
	logic [1:0]     idle_status;
	logic           idle_scan;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [31:0]    ram_wdata;
	logic [31:0]    ram_rdata;
	logic [7:0]     widest;
	logic [7:0]     span;
	logic [3:0][7:0] means;
	vbs_arith_req_t arith_req;
	vbs_arith_rsp_t arith_rsp;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;

	always_comb begin
		ex  = eff_of(size_x_q);
		ey  = eff_of(size_y_q);
		ez  = eff_of(size_z_q);
		qx0 = clamp_of(in_data.lo_x, ex);
		qy0 = clamp_of(in_data.lo_y, ey);
		qz0 = clamp_of(in_data.lo_z, ez);
		qx1 = clamp_of(in_data.hi_x, ex);
		qy1 = clamp_of(in_data.hi_y, ey);
		qz1 = clamp_of(in_data.hi_z, ez);
		wr_inside = ({1'b0, in_data.lo_x} < 8'(ex)) && ({1'b0, in_data.lo_y} < 8'(ey))
			&& ({1'b0, in_data.lo_z} < 8'(ez));
		idle_status = STAT_OK;
		idle_scan   = 1'b0;
		unique case (in_data.opcode) inside
			OP_WRITE: begin
				idle_status = wr_inside ? STAT_OK : STAT_OUTSIDE;
			end
			OP_RANGE, OP_STDDEV: begin
				if (qx1 <= qx0 || qy1 <= qy0 || qz1 <= qz0) begin
					idle_status = STAT_EMPTY;
				end else begin
					idle_scan = 1'b1;
				end
			end
			default: idle_status = STAT_OK;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
		ram_addr  = addr_of(cx_q, cy_q, cz_q);
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_wdata = '0;
			ram_addr  = clr_q;
		end else if (state_q == S_IDLE) begin
			ram_addr = addr_of(CW'(in_data.lo_x), CW'(in_data.lo_y), CW'(in_data.lo_z));
			ram_we   = in_acc && (in_data.opcode == OP_WRITE) && wr_inside;
		end
	end

	vbs_voxel_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign arith_req.start  = arith_go_q;
	assign arith_req.stddev = stddev_q;

	vbs_arith #(
		.NW  (NW),
		.S1W (S1W),
		.S2W (S2W)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arith_req),
		.n      (n_q),
		.sum1   (sum1_q),
		.sum2   (sum2_q),
		.rsp    (arith_rsp),
		.means  (means)
	);

	always_comb begin
		widest = '0;
		span   = '0;
		for (int c = 0; c < 4; c++) begin
			span = mx_q[c] - mn_q[c];
			if (span > widest) widest = span;
		end
	end

	// Accumulators follow the registered read data, in the cycle after each scan read.
	always_ff @(posedge clk) begin
		if (state_q == S_PREP1) begin
			sum1_q <= '0;
			sum2_q <= '0;
			mn_q   <= {4{8'hFF}};
			mx_q   <= '0;
		end else if (rd_valid_s1) begin
			for (int c = 0; c < 4; c++) begin
				sum1_q[c] <= sum1_q[c] + S1W'(ram_rdata[8*c +: 8]);
				sum2_q[c] <= sum2_q[c]
					+ S2W'({8'd0, ram_rdata[8*c +: 8]} * {8'd0, ram_rdata[8*c +: 8]});
				if (ram_rdata[8*c +: 8] < mn_q[c]) mn_q[c] <= ram_rdata[8*c +: 8];
				if (ram_rdata[8*c +: 8] > mx_q[c]) mx_q[c] <= ram_rdata[8*c +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SIZE_X: size_x_q <= cfg_data;
				CFG_SIZE_Y: size_y_q <= cfg_data;
				CFG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			arith_go_q  <= 1'b0;
			out_valid_q <= 1'b0;
			stddev_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			arith_go_q  <= (state_q == S_DRAIN);
			if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						res_q    <= {56'd0, idle_status};
						stddev_q <= (in_data.opcode == OP_STDDEV);
						x0_q <= qx0;
						y0_q <= qy0;
						x1_q <= qx1;
						y1_q <= qy1;
						z1_q <= qz1;
						cx_q <= qx0;
						cy_q <= qy0;
						cz_q <= qz0;
						dx_q <= qx1 - qx0;
						dy_q <= qy1 - qy0;
						dz_q <= qz1 - qz0;
						state_q <= idle_scan ? S_PREP1 : S_FINISH;
					end
				end
				S_PREP1: begin
					nxy_q   <= dx_q * dy_q;
					state_q <= S_PREP2;
				end
				S_PREP2: begin
					n_q     <= NW'(nxy_q * dz_q);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (CW'(cx_q + 1'b1) == x1_q) begin
						cx_q <= x0_q;
						if (CW'(cy_q + 1'b1) == y1_q) begin
							cy_q <= y0_q;
							if (CW'(cz_q + 1'b1) == z1_q) begin
								state_q <= S_DRAIN;
							end else begin
								cz_q <= cz_q + 1'b1;
							end
						end else begin
							cy_q <= cy_q + 1'b1;
						end
					end else begin
						cx_q <= cx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_ARITH;
				end
				S_ARITH: begin
					if (arith_rsp.done) begin
						res_q <= {means[0], means[1], means[2], means[3],
							(stddev_q ? 8'd0 : widest),
							(stddev_q ? arith_rsp.dev : 16'd0), STAT_OK};
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_we_only_idle_or_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("voxel memory written outside clearing or idle");

	a_read_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == S_SCAN))
		else $error("read data marked valid without a scan read");

	a_arith_done_in_arith: assert property (@(posedge clk) disable iff (!arst_n)
		arith_rsp.done |-> (state_q == S_ARITH))
		else $error("arithmetic result outside arithmetic phase");

endmodule
